// ----- sv/puzzle_hash_nonce_solver_defines.svh -----
// Assertion macros for the nonce solver.
`ifndef PUZZLE_HASH_NONCE_SOLVER_DEFINES_SVH
`define PUZZLE_HASH_NONCE_SOLVER_DEFINES_SVH
`ifndef SYNTH
`define PHN_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PHN_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PHN_ASSERT_IMP(label, clk, rst_n, a, c)
`define PHN_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- sv/phns_pkg.sv -----
package phns_pkg;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] MSG_BITS = 32'd136;   // 17 bytes
    localparam logic        OP_HASH  = 1'b0;
    localparam logic        OP_SOLVE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] nonce;
        logic [31:0] puzzle;
        logic [31:0] target_addr;
        logic [31:0] target_port_num;
        logic [7:0]  kind_byte;
        logic [31:0] limit;
    } t_req;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, set nonce
        logic start;      // begin hash of current nonce
        logic round;      // execute one round
        logic finish;     // add init values, fold
        logic next_nonce; // advance search nonce
        logic [5:0] rnd;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_solve;
        logic limit_zero;
        logic hit;       // folded < limit
        logic last_nonce;
    } t_sts;

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- sv/phns_if.sv -----
interface phns_req_if import phns_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface phns_rsp_if import phns_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/phns_datapath.sv -----
module phns_datapath import phns_pkg::*; (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    output t_sts        o_sts,
    output logic [31:0] o_folded,
    output logic [31:0] o_nonce
);
    t_req        r_req;
    logic [31:0] r_nonce, n_nonce;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_fold;
    logic [31:0] wt, s0w, s1w, wnew, t1, t2, bs1, bs0, ch, mj;
    logic [31:0] h0, h1, h2, h3, h4, h5, h6, h7, x0, x1, x2, x3;

    assign n_nonce = (i_cmd.load) ? ((i_req.operation == OP_SOLVE) ? 32'd1 : i_req.nonce)
                                  : r_nonce + 32'd1;

    // message schedule as a 16-word shift window
    assign wt  = r_w[0];
    assign s0w = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1w = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wnew = r_w[0] + s0w + r_w[9] + s1w;

    assign bs1 = rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25);
    assign ch  = (r_e & r_f) ^ (~r_e & r_g);
    assign t1  = r_h + bs1 + ch + K_ROUND[i_cmd.rnd] + wt;
    assign bs0 = rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22);
    assign mj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2  = bs0 + mj;

    assign h0 = H_INIT[0] + r_a;  assign h1 = H_INIT[1] + r_b;
    assign h2 = H_INIT[2] + r_c;  assign h3 = H_INIT[3] + r_d;
    assign h4 = H_INIT[4] + r_e;  assign h5 = H_INIT[5] + r_f;
    assign h6 = H_INIT[6] + r_g;  assign h7 = H_INIT[7] + r_h;
    assign x0 = h0 ^ h1;  assign x1 = h2 ^ h3;
    assign x2 = h4 ^ h5;  assign x3 = h6 ^ h7;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.load || i_cmd.next_nonce) begin
            r_nonce <= n_nonce;
        end
        if (i_cmd.start) begin
            r_w[0] <= bswap(r_nonce);
            r_w[1] <= bswap(r_req.puzzle);
            r_w[2] <= bswap(r_req.target_addr);
            r_w[3] <= bswap(r_req.target_port_num);
            r_w[4] <= {r_req.kind_byte, 24'h800000};
            for (int i = 5; i < 15; i++) r_w[i] <= '0;
            r_w[15] <= MSG_BITS;
            r_a <= H_INIT[0]; r_b <= H_INIT[1]; r_c <= H_INIT[2]; r_d <= H_INIT[3];
            r_e <= H_INIT[4]; r_f <= H_INIT[5]; r_g <= H_INIT[6]; r_h <= H_INIT[7];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= wnew;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
        if (i_cmd.finish) begin
            r_fold <= {x0[31:24] ^ x0[23:16] ^ x0[15:8] ^ x0[7:0],
                       x1[31:24] ^ x1[23:16] ^ x1[15:8] ^ x1[7:0],
                       x2[31:24] ^ x2[23:16] ^ x2[15:8] ^ x2[7:0],
                       x3[31:24] ^ x3[23:16] ^ x3[15:8] ^ x3[7:0]};
        end
    end

    assign o_sts.is_solve   = (r_req.operation == OP_SOLVE);
    assign o_sts.limit_zero = (r_req.limit == 32'd0);
    assign o_sts.hit        = (r_fold < r_req.limit);
    assign o_sts.last_nonce = (r_nonce == 32'hffffffff);
    assign o_folded = r_fold;
    assign o_nonce  = r_nonce;
endmodule

// ----- sv/phns_ctrl.sv -----
module phns_ctrl import phns_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    output logic o_rsp_found,
    output logic o_rsp_use_fold,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [5:0] r_rnd, n_rnd;
    logic       r_found, n_found, r_fold, n_fold;
    logic       acc;

    assign acc = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign o_rsp_found = r_found;
    assign o_rsp_use_fold = r_fold;

    always_comb begin
        n_state = r_state;
        n_rnd = r_rnd;
        n_found = r_found;
        n_fold = r_fold;
        o_cmd = '0;
        o_cmd.rnd = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_solve && i_sts.limit_zero) begin
                    n_found = 1'b0; n_fold = 1'b0; n_state = S_OUT;
                end else begin
                    o_cmd.start = 1'b1; n_rnd = '0; n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (!i_sts.is_solve) begin
                    n_found = 1'b1; n_fold = 1'b1; n_state = S_OUT;
                end else if (i_sts.hit) begin
                    n_found = 1'b1; n_fold = 1'b0; n_state = S_OUT;
                end else if (i_sts.last_nonce) begin
                    n_found = 1'b0; n_fold = 1'b0; n_state = S_OUT;
                end else begin
                    o_cmd.next_nonce = 1'b1; n_state = S_START;
                end
            end
            S_OUT: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd <= '0;
            r_found <= 1'b0;
            r_fold <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd <= n_rnd;
            r_found <= n_found;
            r_fold <= n_fold;
        end
    end
endmodule

// ----- sv/puzzle_hash_nonce_solver.sv -----
// SHA-256 proof-of-work hash and nonce search. One request in, one result out.
// A hash request runs through one setup step, 64 rounds on a single shared round
// unit, one fold step and one check step before the result is valid.
// A solve request repeats this hash loop for each nonce tried, from 1 upward,
// until a nonce wins; a zero limit answers from the setup step without hashing.
// One request is worked on at a time; the next is accepted after the result is taken.
`include "puzzle_hash_nonce_solver_defines.svh"
module puzzle_hash_nonce_solver import phns_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    phns_req_if.sink      i_req,
    phns_rsp_if.source    o_rsp
);
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] folded, nonce;
    logic        found, use_fold;

    phns_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req.valid),
        .o_req_ready    (i_req.ready),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_rsp_found    (found),
        .o_rsp_use_fold (use_fold),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    phns_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_req    (i_req.payload),
        .o_sts    (sts),
        .o_folded (folded),
        .o_nonce  (nonce)
    );

    // failed search reports nonce 0
    assign o_rsp.payload.value = use_fold ? folded : (found ? nonce : 32'd0);
    assign o_rsp.payload.found = found;

    `PHN_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_rsp.valid, !i_req.ready)
    `PHN_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
                    o_rsp.valid && $stable(o_rsp.payload))
    `PHN_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1,
                    $onehot0({cmd.load, cmd.start, cmd.round, cmd.finish, cmd.next_nonce}))
endmodule

// ----- bench/solver_checker.sv -----
module solver_checker import phns_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_rsp expected_results[$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] le_word(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Single-block SHA-256 of the 17-byte message, digest folded to 32 bits.
    function automatic logic [31:0] fold_digest(input logic [31:0] nonce,
                                                input t_req r);
        logic [31:0] w [64];
        logic [31:0] h [8];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, x;
        logic [31:0] folded;
        for (int i = 0; i < 64; i++) w[i] = '0;
        w[0] = le_word(nonce);
        w[1] = le_word(r.puzzle);
        w[2] = le_word(r.target_addr);
        w[3] = le_word(r.target_port_num);
        w[4] = {r.kind_byte, 24'h800000};
        w[15] = MSG_BITS;
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        a = H_INIT[0]; b = H_INIT[1]; c = H_INIT[2]; d = H_INIT[3];
        e = H_INIT[4]; f = H_INIT[5]; g = H_INIT[6]; hh = H_INIT[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + K_ROUND[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        h[0] = H_INIT[0] + a; h[1] = H_INIT[1] + b;
        h[2] = H_INIT[2] + c; h[3] = H_INIT[3] + d;
        h[4] = H_INIT[4] + e; h[5] = H_INIT[5] + f;
        h[6] = H_INIT[6] + g; h[7] = H_INIT[7] + hh;
        for (int i = 0; i < 4; i++) begin
            x = h[2*i] ^ h[2*i+1];
            folded[31-8*i -: 8] = x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
        end
        return folded;
    endfunction

    function automatic t_rsp solve_request(input t_req r);
        t_rsp res;
        logic [31:0] n;
        res = '0;
        if (r.operation == OP_HASH) begin
            res.value = fold_digest(r.nonce, r);
            res.found = 1'b1;
        end else if (r.limit != 0) begin
            n = 32'd1;
            do begin
                if (fold_digest(n, r) < r.limit) begin
                    res.value = n;
                    res.found = 1'b1;
                    break;
                end
                n++;
            end while (n != 0);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_results.push_back(solve_request(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result value=%h found=%b", i_rsp.value, i_rsp.found);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.value !== i_rsp.value) begin
                        $error("value: expected %h actual %h", want.value, i_rsp.value);
                        errs++;
                    end
                    if (want.found !== i_rsp.found) begin
                        $error("found: expected %b actual %b", want.found, i_rsp.found);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= expected_results.size();
        end
    end
endmodule

// ----- bench/testbench.sv -----
module testbench import phns_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 430;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_phase = 0;     // 0: sender idles more lightly, 1: swapped, 2: no idling

    phns_req_if req_ch ();
    phns_rsp_if rsp_ch ();

    always #2 i_clk = ~i_clk;

    puzzle_hash_nonce_solver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    solver_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.payload),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp       (rsp_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Offer one item and hold it until the block takes it, then maybe idle.
    task automatic send_item(input t_req r);
        int idle_pct;
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        idle_pct = (idle_phase == 0) ? 20 : (idle_phase == 1) ? 55 : 0;
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_req random_item();
        t_req r;
        r.operation = ($urandom_range(99) < 70) ? OP_HASH : OP_SOLVE;
        r.nonce = $urandom;
        r.puzzle = $urandom;
        r.target_addr = $urandom;
        r.target_port_num = $urandom;
        r.kind_byte = 8'($urandom);
        // solve limits stay high so the search ends after a few nonces
        if (r.operation == OP_SOLVE)
            r.limit = ($urandom_range(19) == 0) ? 32'd0
                                                : $urandom_range(32'hffffffff, 32'h10000000);
        else
            r.limit = $urandom;
        return r;
    endfunction

    function automatic t_req make_item(input logic op, input logic [31:0] nonce,
                                       input logic [31:0] fill, input logic [7:0] kind,
                                       input logic [31:0] lim);
        t_req r;
        r = '{operation: op, nonce: nonce, puzzle: fill, target_addr: fill,
              target_port_num: fill, kind_byte: kind, limit: lim};
        return r;
    endfunction

    // Stimulus: directed corners, then random items over three idle phases.
    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hash corners: all-zero, all-one and mixed fields
        send_item(make_item(OP_HASH, 32'h0, 32'h0, 8'h00, 32'h0));
        send_item(make_item(OP_HASH, 32'hffffffff, 32'hffffffff, 8'hff, 32'hffffffff));
        send_item(make_item(OP_HASH, 32'h1, 32'h0, 8'hff, 32'h0));
        send_item(make_item(OP_HASH, 32'h80000000, 32'h12345678, 8'h80, 32'h1));
        send_item(make_item(OP_HASH, 32'h00ff00ff, 32'hffffffff, 8'h00, 32'h0));
        // solve with a zero limit answers not-found right away
        send_item(make_item(OP_SOLVE, 32'h0, 32'h0, 8'h00, 32'h0));
        send_item(make_item(OP_SOLVE, 32'hffffffff, 32'hffffffff, 8'hff, 32'h0));
        // widest limit, where the first nonce nearly always wins, then narrower ones; nonce field ignored
        send_item(make_item(OP_SOLVE, 32'hdeadbeef, 32'h0, 8'h00, 32'hffffffff));
        send_item(make_item(OP_SOLVE, 32'h0, 32'hffffffff, 8'hff, 32'hffffffff));
        send_item(make_item(OP_SOLVE, 32'h0, 32'ha5a5a5a5, 8'h5a, 32'h80000000));
        send_item(make_item(OP_SOLVE, 32'h7, 32'h0000ffff, 8'h01, 32'h20000000));
        // hash of nonce one, the first one a search tries
        send_item(make_item(OP_HASH, 32'h1, 32'ha5a5a5a5, 8'h5a, 32'h0));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_phase = (i < RANDOM_ITEMS / 3) ? 0 : (i < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            if (i == 60) begin
                // drain fully before carrying on
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_item(random_item());
        end
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls per phase, plus one long hold-off so the
    // block fills up and back-pressures its input.
    initial begin
        int ready_pct;
        int items_seen;
        bit held;
        rsp_ch.ready = 1'b0;
        items_seen = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) items_seen++;
            if (!held && items_seen == 30) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            ready_pct = (idle_phase == 0) ? 45 : (idle_phase == 1) ? 80 : 100;
            rsp_ch.ready <= ($urandom_range(99) < ready_pct);
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end
endmodule
